FILE: rtl/kclc_pkg.sv
`timescale 1ns / 1ps
// Package of shared types, constants and helpers for the keypad code lock controller.
package kclc_pkg;

	// Code length and widths
	localparam int CODE_DIGITS = 6;
	localparam int CODE_W      = 20;
	localparam int TICK_W      = 16;
	localparam int FAIL_W      = 4;
	localparam int CNT_W       = 3;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;

	// Key characters
	localparam logic [7:0] KEY_NONE = 8'h00;
	localparam logic [7:0] KEY_0    = 8'h30;
	localparam logic [7:0] KEY_1    = 8'h31;
	localparam logic [7:0] KEY_9    = 8'h39;

	// Multiplier applied to the code accumulator per digit
	localparam logic [CODE_W-1:0] DIGIT_BASE = CODE_W'(10);

	// Saturation point of the failure counter
	localparam logic [FAIL_W-1:0] FAIL_MAX = 4'd15;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_DEFAULT_CODE  = 3'd0;
	localparam logic [2:0] REG_FAIL_LIMIT    = 3'd1;
	localparam logic [2:0] REG_OPEN_TICKS    = 3'd2;
	localparam logic [2:0] REG_ALARM_TICKS   = 3'd3;
	localparam logic [2:0] REG_LOCKOUT_TICKS = 3'd4;

	// Register reset values
	localparam logic [CODE_W-1:0] RST_DEFAULT_CODE  = '0;
	localparam logic [FAIL_W-1:0] RST_FAIL_LIMIT    = 4'd3;
	localparam logic [TICK_W-1:0] RST_OPEN_TICKS    = 16'd8;
	localparam logic [TICK_W-1:0] RST_ALARM_TICKS   = 16'd8;
	localparam logic [TICK_W-1:0] RST_LOCKOUT_TICKS = 16'd240;

	// Controller state, one-hot
	typedef enum logic [4:0] {
		MODE_ENTER  = 5'b00001,
		MODE_NEW    = 5'b00010,
		MODE_CHOICE = 5'b00100,
		MODE_HOLD   = 5'b01000,
		MODE_LOCK   = 5'b10000
	} mode_t;

	// What follows the end of a hold
	typedef enum logic [1:0] {
		AFTER_ENTER  = 2'd0,
		AFTER_CHOICE = 2'd1,
		AFTER_LOCK   = 2'd2
	} after_t;

	// Event codes reported with each result
	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_TAKEN      = 3'd1,
		EV_CORRECT    = 3'd2,
		EV_WRONG      = 3'd3,
		EV_LOCK_BEGIN = 3'd4,
		EV_NEW_SET    = 3'd5,
		EV_LOCK_END   = 3'd6,
		EV_IGNORED    = 3'd7
	} event_t;

	// Configuration register set
	typedef struct packed {
		logic [CODE_W-1:0] default_code;
		logic [FAIL_W-1:0] fail_limit;
		logic [TICK_W-1:0] open_ticks;
		logic [TICK_W-1:0] alarm_ticks;
		logic [TICK_W-1:0] lockout_ticks;
	} cfg_t;

	// One result transaction
	typedef struct packed {
		logic              door_open;
		logic              red_led;
		logic [2:0]        mode;
		logic [CNT_W-1:0]  digit_count;
		logic [2:0]        event_res;
		logic [FAIL_W-1:0] tries_left;
		logic [TICK_W-1:0] ticks_left;
	} res_t;

	// Numeric mode code as reported on the result channel
	function automatic logic [2:0] mode_code(input mode_t m);
		logic [2:0] c;
		case (m)
			MODE_ENTER:  c = 3'd0;
			MODE_NEW:    c = 3'd1;
			MODE_CHOICE: c = 3'd2;
			MODE_HOLD:   c = 3'd3;
			MODE_LOCK:   c = 3'd4;
			default:     c = 3'd0;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/kclc_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register bank behind the APB-style port.
module kclc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kclc_pkg::ADDR_W-1:0]   paddr,
	input  logic [kclc_pkg::DATA_W-1:0]   pwdata,
	output logic [kclc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output kclc_pkg::cfg_t                cfg
);

	kclc_pkg::cfg_t cfg_q;
	logic [2:0]     reg_idx;
	logic           wr_en;

	// Word index and write strobe of the access phase
	assign reg_idx = paddr[kclc_pkg::ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.default_code  <= kclc_pkg::RST_DEFAULT_CODE;
			cfg_q.fail_limit    <= kclc_pkg::RST_FAIL_LIMIT;
			cfg_q.open_ticks    <= kclc_pkg::RST_OPEN_TICKS;
			cfg_q.alarm_ticks   <= kclc_pkg::RST_ALARM_TICKS;
			cfg_q.lockout_ticks <= kclc_pkg::RST_LOCKOUT_TICKS;
		end else if (wr_en) begin
			case (reg_idx)
				kclc_pkg::REG_DEFAULT_CODE:
					cfg_q.default_code <= pwdata[kclc_pkg::CODE_W-1:0];
				kclc_pkg::REG_FAIL_LIMIT:
					cfg_q.fail_limit <= pwdata[kclc_pkg::FAIL_W-1:0];
				kclc_pkg::REG_OPEN_TICKS:
					cfg_q.open_ticks <= pwdata[kclc_pkg::TICK_W-1:0];
				kclc_pkg::REG_ALARM_TICKS:
					cfg_q.alarm_ticks <= pwdata[kclc_pkg::TICK_W-1:0];
				kclc_pkg::REG_LOCKOUT_TICKS:
					cfg_q.lockout_ticks <= pwdata[kclc_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back multiplexer
	always_comb begin
		case (reg_idx)
			kclc_pkg::REG_DEFAULT_CODE:
				prdata = kclc_pkg::DATA_W'(cfg_q.default_code);
			kclc_pkg::REG_FAIL_LIMIT:
				prdata = kclc_pkg::DATA_W'(cfg_q.fail_limit);
			kclc_pkg::REG_OPEN_TICKS:
				prdata = kclc_pkg::DATA_W'(cfg_q.open_ticks);
			kclc_pkg::REG_ALARM_TICKS:
				prdata = kclc_pkg::DATA_W'(cfg_q.alarm_ticks);
			kclc_pkg::REG_LOCKOUT_TICKS:
				prdata = kclc_pkg::DATA_W'(cfg_q.lockout_ticks);
			default:
				prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/kclc_core.sv
`timescale 1ns / 1ps
// Lock state registers and the single-pass update for one key or tick transaction.
module kclc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic                action,
	input  logic [7:0]          key_code,
	input  kclc_pkg::cfg_t      cfg,
	output kclc_pkg::res_t      res
);

	kclc_pkg::mode_t                  mode_q, mode_n;
	kclc_pkg::after_t                 after_q, after_n;
	logic [kclc_pkg::CNT_W-1:0]       digits_q, digits_n;
	logic [kclc_pkg::CODE_W-1:0]      acc_q, acc_n;
	logic [kclc_pkg::CODE_W-1:0]      saved_q, saved_n;
	logic                             set_q, set_n;
	logic [kclc_pkg::FAIL_W-1:0]      fails_q, fails_n, fails_inc;
	logic [kclc_pkg::TICK_W-1:0]      timer_q, timer_n;
	kclc_pkg::event_t                 ev;

	logic [kclc_pkg::CODE_W-1:0]      acc_next;
	logic [kclc_pkg::CNT_W-1:0]       digits_inc;
	logic [kclc_pkg::CODE_W-1:0]      want;
	logic [7:0]                       digit_off;
	logic                             is_digit;
	logic                             holding;

	// Accumulator times ten plus the new digit, and the count of digits so far
	assign digit_off  = key_code - kclc_pkg::KEY_0;
	assign acc_next   = acc_q * kclc_pkg::DIGIT_BASE
	                  + kclc_pkg::CODE_W'(digit_off[3:0]);
	assign digits_inc = digits_q + 3'd1;
	assign is_digit   = (key_code >= kclc_pkg::KEY_0) && (key_code <= kclc_pkg::KEY_9);
	assign want       = set_q ? saved_q : cfg.default_code;
	assign fails_inc  = (fails_q < kclc_pkg::FAIL_MAX) ? fails_q + 4'd1 : fails_q;

	// Next-state logic for one transaction
	always_comb begin
		mode_n   = mode_q;
		after_n  = after_q;
		digits_n = digits_q;
		acc_n    = acc_q;
		saved_n  = saved_q;
		set_n    = set_q;
		fails_n  = fails_q;
		timer_n  = timer_q;
		ev       = kclc_pkg::EV_NONE;
		if (action) begin
			// Tick: count down a hold or lockout and act on its end
			if (mode_q == kclc_pkg::MODE_HOLD || mode_q == kclc_pkg::MODE_LOCK) begin
				if (timer_q > 16'd1) begin
					timer_n = timer_q - 16'd1;
				end else begin
					timer_n = '0;
					if (mode_q == kclc_pkg::MODE_LOCK) begin
						fails_n = '0;
						mode_n  = kclc_pkg::MODE_ENTER;
						ev      = kclc_pkg::EV_LOCK_END;
					end else if (after_q == kclc_pkg::AFTER_CHOICE) begin
						mode_n = kclc_pkg::MODE_CHOICE;
					end else if (after_q == kclc_pkg::AFTER_LOCK) begin
						mode_n  = kclc_pkg::MODE_LOCK;
						timer_n = cfg.lockout_ticks;
						after_n = kclc_pkg::AFTER_ENTER;
						ev      = kclc_pkg::EV_LOCK_BEGIN;
					end else begin
						mode_n = kclc_pkg::MODE_ENTER;
					end
				end
			end
		end else if (key_code != kclc_pkg::KEY_NONE) begin
			if (mode_q == kclc_pkg::MODE_HOLD || mode_q == kclc_pkg::MODE_LOCK) begin
				ev = kclc_pkg::EV_IGNORED;
			end else if (mode_q == kclc_pkg::MODE_CHOICE) begin
				// Choice key: '1' starts new-code entry, anything else returns
				mode_n   = (key_code == kclc_pkg::KEY_1) ? kclc_pkg::MODE_NEW
				                                        : kclc_pkg::MODE_ENTER;
				digits_n = '0;
				acc_n    = '0;
				ev       = kclc_pkg::EV_TAKEN;
			end else if (!is_digit) begin
				ev = kclc_pkg::EV_IGNORED;
			end else if (digits_inc < kclc_pkg::CNT_W'(kclc_pkg::CODE_DIGITS)) begin
				acc_n    = acc_next;
				digits_n = digits_inc;
				ev       = kclc_pkg::EV_TAKEN;
			end else begin
				// Code complete: store it or compare it
				digits_n = '0;
				acc_n    = '0;
				if (mode_q == kclc_pkg::MODE_NEW) begin
					saved_n = acc_next;
					set_n   = 1'b1;
					mode_n  = kclc_pkg::MODE_ENTER;
					ev      = kclc_pkg::EV_NEW_SET;
				end else if (acc_next == want) begin
					fails_n = '0;
					mode_n  = kclc_pkg::MODE_HOLD;
					timer_n = cfg.open_ticks;
					after_n = kclc_pkg::AFTER_CHOICE;
					ev      = kclc_pkg::EV_CORRECT;
				end else begin
					fails_n = fails_inc;
					mode_n  = kclc_pkg::MODE_HOLD;
					timer_n = cfg.alarm_ticks;
					after_n = (fails_inc >= cfg.fail_limit) ? kclc_pkg::AFTER_LOCK
					                                        : kclc_pkg::AFTER_ENTER;
					ev      = kclc_pkg::EV_WRONG;
				end
			end
		end
	end

	// State registers, updated once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= kclc_pkg::MODE_ENTER;
			after_q  <= kclc_pkg::AFTER_ENTER;
			digits_q <= '0;
			acc_q    <= '0;
			saved_q  <= '0;
			set_q    <= 1'b0;
			fails_q  <= '0;
			timer_q  <= '0;
		end else if (step_en) begin
			mode_q   <= mode_n;
			after_q  <= after_n;
			digits_q <= digits_n;
			acc_q    <= acc_n;
			saved_q  <= saved_n;
			set_q    <= set_n;
			fails_q  <= fails_n;
			timer_q  <= timer_n;
		end
	end

	// Result fields describe the state after the transaction
	assign holding = (mode_n == kclc_pkg::MODE_HOLD);

	always_comb begin
		res.door_open   = holding && (after_n == kclc_pkg::AFTER_CHOICE);
		res.red_led     = (holding && (after_n != kclc_pkg::AFTER_CHOICE))
		                || (mode_n == kclc_pkg::MODE_LOCK);
		res.mode        = kclc_pkg::mode_code(mode_n);
		res.digit_count = digits_n;
		res.event_res   = ev;
		res.tries_left  = (fails_n >= cfg.fail_limit) ? '0 : cfg.fail_limit - fails_n;
		res.ticks_left  = (holding || mode_n == kclc_pkg::MODE_LOCK) ? timer_n : '0;
	end

endmodule

FILE: rtl/keypad_code_lock_controller_unit.sv
`timescale 1ns / 1ps
// Top level of the keypad code lock controller: input stage, core and result register.
//
// Usage:
//   The item channel (item_valid, item_stall, action, key_code) carries one key
//   press (action 0) or one 250 ms tick (action 1) per transaction. The result
//   channel (res_valid, res_stall and the result fields) returns exactly one
//   transaction per item, showing the lock state after that item.
//   The item is held in the input register after acceptance while the state update
//   runs, and res_valid rises when the result is loaded into the result register.
//   Throughput is one item per cycle while res_stall is low; an item's update is
//   one pass through the core between the input register and the result register.
//   When the receiver holds res_stall, the result register keeps its payload
//   and one further item may wait in the input register; item_stall rises only
//   when both are full.
//   Configuration is written over the APB-style port (pready always high), at byte
//   address 4*i for register i, by the user only while no item is in flight; the
//   block does not enforce this. Asynchronous reset (arst_n low) empties both stages,
//   returns the lock to code entry with no stored code and no failures, and loads
//   the register reset values. No clearing pass is needed; items are taken at once.
module keypad_code_lock_controller_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Item channel
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          action,
	input  logic [7:0]                    key_code,
	// Result channel
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          door_open,
	output logic                          red_led,
	output logic [2:0]                    mode,
	output logic [2:0]                    digit_count,
	output logic [2:0]                    event_res,
	output logic [3:0]                    tries_left,
	output logic [15:0]                   ticks_left,
	// Configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kclc_pkg::ADDR_W-1:0]   paddr,
	input  logic [kclc_pkg::DATA_W-1:0]   pwdata,
	output logic [kclc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	kclc_pkg::cfg_t cfg;
	kclc_pkg::res_t core_res;
	kclc_pkg::res_t res_q;
	logic           res_valid_q;
	logic           valid_s1;
	logic           action_s1;
	logic [7:0]     key_s1;
	logic           advance;
	logic           step_en;

	// Pipeline control: the result register frees up when empty or taken
	assign advance    = !res_valid_q || !res_stall;
	assign step_en    = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			action_s1 <= action;
			key_s1    <= key_code;
		end
	end

	// Configuration registers
	kclc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Lock state and update logic
	kclc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (step_en),
		.action   (action_s1),
		.key_code (key_s1),
		.cfg      (cfg),
		.res      (core_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= core_res;
		end
	end

	assign res_valid   = res_valid_q;
	assign door_open   = res_q.door_open;
	assign red_led     = res_q.red_led;
	assign mode        = res_q.mode;
	assign digit_count = res_q.digit_count;
	assign event_res   = res_q.event_res;
	assign tries_left  = res_q.tries_left;
	assign ticks_left  = res_q.ticks_left;

endmodule
